### rtl/mbid_pkg.sv
// shared types and constants for the multi-button integrating debouncer
// no dependencies
package mbid_pkg;

  localparam int NUM_BUTTONS = 25;
  localparam int RAW_W       = 25;
  localparam int CNT_W       = 4;
  localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int IN_DATA_W   = ((RAW_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((IDX_W + 1 + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(5);

  typedef struct packed {
    logic hit;
    logic pressed;
  } mbid_evt_t;

endpackage

### rtl/mbid_cell.sv
// one button cell: integrator and debounced flag, updated on each tick
// depends on mbid_pkg
module mbid_cell
  import mbid_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             tick,
  input  logic             raw,
  input  logic [CNT_W-1:0] threshold,
  output mbid_evt_t        evt
);

  logic [CNT_W-1:0] integ;
  logic [CNT_W-1:0] integ_next;
  logic             flag;
  logic             flag_next;

  always_comb begin
    integ_next  = integ;
    flag_next   = flag;
    evt.hit     = 1'b0;
    evt.pressed = 1'b0;
    if (!raw) begin
      if (integ < threshold) begin
        integ_next = integ + CNT_W'(1);
        if (integ_next >= threshold && !flag) begin
          flag_next   = 1'b1;
          evt.hit     = 1'b1;
          evt.pressed = 1'b1;
        end
      end
    end else if (integ != '0) begin
      integ_next = integ - CNT_W'(1);
      if (integ_next == '0 && flag) begin
        flag_next = 1'b0;
        evt.hit   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      flag  <= 1'b0;
    end else if (tick) begin
      integ <= integ_next;
      flag  <= flag_next;
    end
  end

endmodule

### rtl/mbid_serializer.sv
// shift chain of event slots, one slot per cycle into the output register while out_ready does not stall it
// depends on mbid_pkg
module mbid_serializer
  import mbid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  mbid_evt_t             load_evt [NUM_BUTTONS],
  output logic                  idle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_W-1:0]      out_index,
  output logic                  out_pressed,
  output logic                  out_last
);

  logic [NUM_BUTTONS-1:0] hit;
  logic [NUM_BUTTONS-1:0] prs;
  logic [IDX_W-1:0]       idx;
  logic                   adv;

  assign idle = (hit == '0);
  assign adv  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit       <= '0;
      out_valid <= 1'b0;
    end else if (idle) begin
      if (adv) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          hit[i] <= load_evt[i].hit;
        end
      end
    end else if (adv) begin
      out_valid <= hit[0];
      hit       <= hit >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (idle && load) begin
      idx <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        prs[i] <= load_evt[i].pressed;
      end
    end else if (!idle && adv) begin
      idx <= idx + IDX_W'(1);
      prs <= prs >> 1;
      if (hit[0]) begin
        out_index   <= idx;
        out_pressed <= prs[0];
        out_last    <= ((hit >> 1) == '0);
      end
    end
  end

endmodule

### rtl/multi_button_integrating_debouncer.sv
// top level: row of button cells, tick event buffer and event serializer
// depends on mbid_pkg, mbid_cell, mbid_serializer
//
// channel  dir  handshake              payload
// s_axis   in   tvalid/tready          tdata[24:0] raw_levels
// m_axis   out  tvalid/tready          tdata[4:0] button_index, [5] pressed, tlast
// config   in   threshold_we           threshold_wdata[3:0]
//
// all cells update in the cycle a tick is accepted; events then leave one
// per cycle at most, the serializer loads a tick from the buffer, then walks
// one button slot per cycle while m_axis does not stall, and stops after the last event;
// a tick's events pass the tick buffer, serializer chain and output register in order
// one tick is buffered while the serializer drains the previous one
// rst is synchronous: integrators and flags clear, threshold returns to 5
// m_axis stalls hold the serializer chain in place
module multi_button_integrating_debouncer
  import mbid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // raw_levels
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // button_index, pressed
  output logic                  m_axis_tlast,   // last_event
  input  logic                  threshold_we,
  input  logic [CNT_W-1:0]      threshold_wdata
);

  logic [CNT_W-1:0]   threshold;
  logic [31:0]        raw_ext;
  logic               tick;
  logic               ser_idle;
  logic               pend_valid;
  logic               load;
  mbid_evt_t          cell_evt [NUM_BUTTONS];
  mbid_evt_t          pend_evt [NUM_BUTTONS];
  logic [IDX_W-1:0]   out_index;
  logic               out_pressed;

  assign raw_ext       = 32'(s_axis_tdata[RAW_W-1:0]);
  assign load          = pend_valid && ser_idle;
  assign s_axis_tready = !pend_valid || ser_idle;
  assign tick          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (threshold_we) begin
      threshold <= threshold_wdata;
    end
  end

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_cell
    mbid_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .tick      (tick),
      .raw       (raw_ext[g]),
      .threshold (threshold),
      .evt       (cell_evt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (tick) begin
      pend_valid <= 1'b1;
    end else if (load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      pend_evt <= cell_evt;
    end
  end

  mbid_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .load_evt    (pend_evt),
    .idle        (ser_idle),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_index   (out_index),
    .out_pressed (out_pressed),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DATA_W'({out_pressed, out_index});

endmodule

### dv/mbid_event_checker.sv
// scoreboard for the multi-button integrating debouncer: follows threshold writes
// and accepted ticks, predicts debounced press and release events, checks m_axis
// depends on mbid_pkg
module mbid_event_checker
  import mbid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,       // raw_levels
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,       // button_index, pressed
  input  logic                  m_axis_tlast,       // last_event
  input  logic                  threshold_we,
  input  logic [CNT_W-1:0]      threshold_wdata,
  output int                    mismatches,
  output int                    events_outstanding
);

  typedef struct packed {
    logic [IDX_W-1:0] button;
    logic             pressed;
    logic             last;
  } button_event_t;

  logic [CNT_W-1:0] threshold;
  logic [CNT_W-1:0] integ [NUM_BUTTONS];
  logic             debounced [NUM_BUTTONS];
  button_event_t    expected_events [$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic integrate_tick(input logic [IN_DATA_W-1:0] levels);
    logic             held_down;
    logic [CNT_W-1:0] v;
    int               first;
    first = expected_events.size();
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      // buttons beyond the input width read as pressed
      held_down = (b >= RAW_W) || !levels[b];
      v = integ[b];
      if (held_down && v < threshold) begin
        v = v + 1'b1;
        if (v >= threshold && !debounced[b]) begin
          debounced[b] = 1'b1;
          expected_events.push_back('{IDX_W'(b), 1'b1, 1'b0});
        end
      end
      if (!held_down && v > 0) begin
        v = v - 1'b1;
        if (v == 0 && debounced[b]) begin
          debounced[b] = 1'b0;
          expected_events.push_back('{IDX_W'(b), 1'b0, 1'b0});
        end
      end
      integ[b] = v;
    end
    if (expected_events.size() > first) expected_events[$].last = 1'b1;
  endtask

  task automatic check_event();
    button_event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("event for button %0d with none expected",
                                m_axis_tdata[IDX_W-1:0]));
      return;
    end
    want = expected_events.pop_front();
    if (m_axis_tdata[IDX_W-1:0] !== want.button)
      report_mismatch($sformatf("button_index %0d, expected %0d",
                                m_axis_tdata[IDX_W-1:0], want.button));
    if (m_axis_tdata[IDX_W] !== want.pressed)
      report_mismatch($sformatf("pressed %0b for button %0d, expected %0b",
                                m_axis_tdata[IDX_W], want.button, want.pressed));
    if (m_axis_tlast !== want.last)
      report_mismatch($sformatf("tlast %0b for button %0d, expected %0b",
                                m_axis_tlast, want.button, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      threshold = THRESHOLD_RESET;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        integ[b]     = '0;
        debounced[b] = 1'b0;
      end
      expected_events.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_event();
      if (threshold_we) threshold = threshold_wdata;
      if (s_axis_tvalid && s_axis_tready) integrate_tick(s_axis_tdata);
    end
    events_outstanding = expected_events.size();
  end

endmodule

### dv/tb.sv
// top of the debouncer testbench: clock, reset, tick stimulus, threshold writes
// and the verdict
// depends on mbid_pkg, multi_button_integrating_debouncer and mbid_event_checker
module tb;
  import mbid_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_TICKS  = 50;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '1;     // raw_levels
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;          // button_index, pressed
  logic                  m_axis_tlast;          // last_event
  logic                  threshold_we = 1'b0;
  logic [CNT_W-1:0]      threshold_wdata = '0;

  int               sender_idle_pct = 0;
  int               receiver_idle_pct = 0;
  int               mismatches;
  int               events_outstanding;
  int               quiet_cycles = 0;
  logic [RAW_W-1:0] held_levels = '1;
  logic [CNT_W-1:0] phase_thresholds [6] = '{4'd5, 4'd15, 4'd1, 4'd0, 4'd9, 4'd3};

  multi_button_integrating_debouncer i_dut (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .threshold_we    (threshold_we),
    .threshold_wdata (threshold_wdata)
  );

  mbid_event_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tlast       (m_axis_tlast),
    .threshold_we       (threshold_we),
    .threshold_wdata    (threshold_wdata),
    .mismatches         (mismatches),
    .events_outstanding (events_outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_tick(input logic [RAW_W-1:0] lv);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(lv);
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [CNT_W-1:0] t);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (events_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    threshold_we    <= 1'b1;
    threshold_wdata <= t;
    @(negedge clk);
    threshold_we    <= 1'b0;
  endtask

  // held buttons that change now and then, with contact bounce and some noise ticks
  function automatic logic [RAW_W-1:0] next_levels();
    logic [RAW_W-1:0] lv;
    for (int b = 0; b < RAW_W; b++)
      if ($urandom_range(23) == 0) held_levels[b] = ~held_levels[b];
    if ($urandom_range(99) < 15) begin
      lv = RAW_W'($urandom);
    end else begin
      lv = held_levels;
      for (int b = 0; b < RAW_W; b++)
        if ($urandom_range(15) == 0) lv[b] = ~lv[b];
    end
    return lv;
  endfunction

  initial begin
    sender_idle_pct   = 38;
    receiver_idle_pct = 45;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // every button confirms on the same tick at the reset threshold
    repeat (5) send_tick('0);
    // threshold zero: no rise, releases still count down
    write_threshold(4'd0);
    send_tick('0);
    repeat (5) send_tick('1);
    write_threshold(4'd3);
    repeat (4) send_tick('0);
    // threshold lowered below the integrators
    write_threshold(4'd1);
    send_tick('0);
    repeat (3) send_tick(25'h1555555);

    for (int p = 0; p < 6; p++) begin
      write_threshold(phase_thresholds[p]);
      if (p == 2) begin
        sender_idle_pct   = 45;
        receiver_idle_pct = 38;
      end else if (p == 4) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      repeat (RANDOM_TICKS) send_tick(next_levels());
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (events_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
